// ===== design/reorder_window_range_nak_macros.svh =====
// Assertion macros used by the engine design file.
`ifndef REORDER_WINDOW_RANGE_NAK_MACROS_SVH
`define REORDER_WINDOW_RANGE_NAK_MACROS_SVH

// Holds at every edge out of reset.
`define RWRN_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define RWRN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RWRN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rwrn_pkg.sv =====
`timescale 1ns / 1ps
package rwrn_pkg;

    localparam int IDX_W   = 31;
    localparam int CNT_W   = 11;
    localparam int Q_DEPTH = 2;
    localparam logic [4:0] DIV_STEPS = 5'd3;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_REPORT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_RANGE  = 2'd1,
        KIND_DROP   = 2'd2
    } t_kind;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] range_index;
        logic             run_start;
        logic [CNT_W-1:0] released_count;
        logic [IDX_W-1:0] next_expected;
        logic             last;
    } t_result;

    typedef struct packed {
        logic recv;
        logic pend;
    } t_entry;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ARR,
        ST_REL,
        ST_WALK,
        ST_WEND,
        ST_FLUSH
    } t_state;

endpackage

// ===== design/rwrn_front.sv =====
`timescale 1ns / 1ps
module rwrn_front import rwrn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_packet_index,
    output logic             o_stall,
    output t_cmd             o_cmd,
    output logic             o_cmd_valid,
    input  logic             i_cmd_take
);

    t_cmd       r_q [Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    logic       push, pop;
    t_cmd       cmd_in;

    assign o_stall     = (r_cnt == 2'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_take && o_cmd_valid;
    assign cmd_in      = '{op: t_op'(i_operation), idx: i_packet_index};

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ===== design/rwrn_engine.sv =====
`timescale 1ns / 1ps
`include "reorder_window_range_nak_macros.svh"
module rwrn_engine import rwrn_pkg::*; #(
    parameter int WINDOW           = 1024,
    parameter int MAX_REPORT_WORDS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_take,
    output t_result          o_result,
    output logic             o_valid,
    input  logic             i_stall
);

    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = AW + 1;
    localparam int WDW = $clog2(MAX_REPORT_WORDS + 2);
    localparam int RK  = IDX_W + AW;
    localparam logic [CW-1:0]    W_C    = CW'(WINDOW);
    localparam logic [AW-1:0]    W_LAST = AW'(WINDOW - 1);
    localparam logic [WDW-1:0]   W_MAXW = WDW'(MAX_REPORT_WORDS);
    localparam logic [IDX_W-1:0] W_IDX  = IDX_W'(WINDOW);
    localparam logic [IDX_W:0]   RECIP  = (IDX_W+1)'((64'd1 << RK) / WINDOW);
    localparam logic [AW-1:0]    W_WRAP = AW'((64'd1 << IDX_W) % WINDOW);

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s,
                                               input logic [CW-1:0] d);
        logic [CW-1:0] sum;
        sum = {1'b0, s} + d;
        if (sum >= W_C) begin
            sum = sum - W_C;
        end
        return AW'(sum);
    endfunction

    function automatic logic [AW-1:0] slot_adv(input logic [AW-1:0]    s,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [CW-1:0]    d);
        logic [IDX_W:0] sum;
        logic [AW-1:0]  t;
        sum = {1'b0, idx} + (IDX_W+1)'(d);
        t   = slot_add(s, d);
        if (sum[IDX_W]) begin
            t = (t >= W_WRAP) ? t - W_WRAP : AW'({1'b0, t} + W_C - {1'b0, W_WRAP});
        end
        return t;
    endfunction

    t_entry r_mem [WINDOW];
    t_entry r_rd;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head, r_base, n_base;
    logic [AW-1:0]    r_head_slot, n_head_slot, r_base_slot, n_base_slot;
    logic [AW-1:0]    r_ptr, n_ptr, r_off, n_off, r_wslot, n_wslot, r_prev, n_prev;
    logic [CW-1:0]    r_count, n_count, r_clr, n_clr;
    logic             r_have, n_have, r_in_run, n_in_run, r_cut, n_cut;
    logic [WDW-1:0]   r_words, n_words;
    t_result          r_hold, n_hold, r_out, n_out;
    logic             r_hold_valid, n_hold_valid, r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_div, n_div;
    logic [IDX_W-1:0] r_quo, n_quo;
    logic [CW-1:0]    r_part, n_part;
    logic [AW-1:0]    r_rem, n_rem;
    logic [4:0]       r_bits, n_bits;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    t_entry           mem_wdata;

    logic             take, out_can_load, emit_ok;
    logic [IDX_W-1:0] arr_dh, arr_db;
    logic             arr_stale, arr_drop;
    logic [AW-1:0]    arr_slot;
    logic             rel_go;
    logic [CW-1:0]    prev_p1;
    logic             gap, need_emit, walk_stall, walk_last, cut_now, wend_stall;
    logic [WDW-1:0]   words_n;
    logic [IDX_W-1:0] h_dist;
    logic             c_lt_h;
    logic             clr_done, div_done, init_done;
    logic [2*IDX_W:0] mul_p;
    logic             emit_fire, out_load;
    t_result          emit_val, out_val;

    assign take         = (r_state == ST_IDLE) && i_cmd_valid && !i_cfg_we;
    assign o_cmd_take   = take;
    assign out_can_load = !r_out_valid || !i_stall;
    assign emit_ok      = !r_hold_valid || out_can_load;
    assign o_result     = r_out;
    assign o_valid      = r_out_valid;

    assign arr_dh    = i_cmd.idx - r_head;
    assign arr_db    = i_cmd.idx - r_base;
    assign arr_stale = arr_dh[IDX_W-1];
    assign arr_drop  = (arr_db >= IDX_W'(WINDOW));
    assign arr_slot  = slot_adv(r_base_slot, r_base, CW'(arr_db));

    assign rel_go = r_rd.recv && (r_count < W_C);

    assign prev_p1    = {1'b0, r_prev} + 1'b1;
    assign gap        = (prev_p1 != {1'b0, r_off});
    assign need_emit  = r_rd.pend && r_have && (gap || !r_in_run);
    assign walk_stall = need_emit && !emit_ok;
    assign words_n    = r_words + WDW'(need_emit);
    assign cut_now    = r_rd.pend && r_have && gap && (words_n >= W_MAXW);
    assign walk_last  = cut_now || (r_off == W_LAST);
    assign wend_stall = r_have && !emit_ok;

    assign h_dist = r_head - r_base;
    assign c_lt_h = (IDX_W'(prev_p1) < h_dist);

    assign clr_done  = (r_clr == W_C);
    assign div_done  = (r_bits == DIV_STEPS);
    assign init_done = clr_done && div_done;
    assign mul_p     = (2*IDX_W+1)'(r_div) * (2*IDX_W+1)'(RECIP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (init_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (take) begin
                    if (i_cmd.op == OP_REPORT) n_state = ST_REL;
                    else if (arr_stale) n_state = ST_IDLE;
                    else if (arr_drop) n_state = ST_FLUSH;
                    else n_state = ST_ARR;
                end
            end
            ST_ARR: n_state = ST_IDLE;
            ST_REL: begin
                if (!rel_go) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!walk_stall && walk_last) n_state = ST_WEND;
            end
            ST_WEND: begin
                if (!wend_stall) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (out_can_load) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
        if (i_cfg_we) n_state = ST_INIT;
    end

    always_comb begin
        n_head = r_head;  n_base = r_base;
        n_head_slot = r_head_slot;  n_base_slot = r_base_slot;
        n_ptr = r_ptr;  n_off = r_off;  n_wslot = r_wslot;  n_prev = r_prev;
        n_count = r_count;  n_clr = r_clr;
        n_have = r_have;  n_in_run = r_in_run;  n_cut = r_cut;  n_words = r_words;
        n_hold = r_hold;  n_hold_valid = r_hold_valid;
        n_div = r_div;  n_quo = r_quo;  n_part = r_part;  n_rem = r_rem;  n_bits = r_bits;
        mem_we = 1'b0;  mem_waddr = r_head_slot;  mem_wdata = '0;
        mem_raddr = r_head_slot;
        emit_fire = 1'b0;  emit_val = '0;

        unique case (r_state)
            ST_INIT: begin
                if (!clr_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_clr);
                    n_clr     = r_clr + 1'b1;
                end
                if (!div_done) begin
                    n_bits = r_bits + 1'b1;
                    if (r_bits == 5'd0) begin
                        n_quo = IDX_W'(mul_p >> RK);
                    end else if (r_bits == 5'd1) begin
                        n_part = CW'(r_div - r_quo * W_IDX);
                    end else begin
                        n_rem = AW'((r_part >= W_C) ? r_part - W_C : r_part);
                    end
                end
                if (init_done) begin
                    n_head_slot = r_rem;
                    n_base_slot = r_rem;
                end
            end
            ST_IDLE: begin
                n_count = '0;
                if (take && i_cmd.op == OP_ARRIVE) begin
                    mem_raddr = arr_slot;
                    n_ptr     = arr_slot;
                    if (!arr_stale && arr_drop) begin
                        n_hold       = '0;
                        n_hold.kind  = KIND_DROP;
                        n_hold_valid = 1'b1;
                    end
                end
            end
            ST_ARR: begin
                if (!r_rd.recv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr;
                    mem_wdata = '{recv: 1'b1, pend: 1'b1};
                end
            end
            ST_REL: begin
                if (rel_go) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_head_slot;
                    mem_wdata   = '{recv: 1'b0, pend: r_rd.pend};
                    n_head      = r_head + 1'b1;
                    n_head_slot = slot_adv(r_head_slot, r_head, CW'(1));
                    mem_raddr   = slot_adv(r_head_slot, r_head, CW'(1));
                    n_count     = r_count + 1'b1;
                end else begin
                    n_hold                = '0;
                    n_hold.kind           = KIND_STATUS;
                    n_hold.released_count = CNT_W'(r_count);
                    n_hold.next_expected  = r_head;
                    n_hold_valid          = 1'b1;
                    n_off     = '0;
                    n_wslot   = r_base_slot;
                    mem_raddr = r_base_slot;
                    n_have    = 1'b0;
                    n_in_run  = 1'b0;
                    n_cut     = 1'b0;
                    n_words   = '0;
                end
            end
            ST_WALK: begin
                mem_raddr = r_wslot;
                if (!walk_stall) begin
                    if (r_rd.pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wslot;
                        mem_wdata = '{recv: r_rd.recv, pend: 1'b0};
                        if (r_have) begin
                            n_in_run = !gap;
                            n_words  = words_n;
                        end
                        n_have = 1'b1;
                        n_prev = r_off;
                    end
                    if (need_emit) begin
                        emit_fire            = 1'b1;
                        emit_val.kind        = KIND_RANGE;
                        emit_val.range_index = r_base + IDX_W'(r_prev);
                        emit_val.run_start   = !gap;
                    end
                    n_cut     = cut_now;
                    n_off     = r_off + 1'b1;
                    n_wslot   = slot_adv(r_wslot, r_base + IDX_W'(r_off), CW'(1));
                    mem_raddr = slot_adv(r_wslot, r_base + IDX_W'(r_off), CW'(1));
                end
            end
            ST_WEND: begin
                if (!wend_stall) begin
                    if (r_have) begin
                        emit_fire            = 1'b1;
                        emit_val.kind        = KIND_RANGE;
                        emit_val.range_index = r_base + IDX_W'(r_prev);
                    end
                    if (r_cut && c_lt_h) begin
                        n_base      = r_base + IDX_W'(prev_p1);
                        n_base_slot = slot_adv(r_base_slot, r_base, prev_p1);
                    end else begin
                        n_base      = r_head;
                        n_base_slot = r_head_slot;
                    end
                end
            end
            ST_FLUSH: begin
            end
            default: begin
            end
        endcase

        out_load = 1'b0;
        out_val  = r_hold;
        if (r_state == ST_FLUSH && out_can_load) begin
            out_load     = 1'b1;
            out_val.last = 1'b1;
            n_hold_valid = 1'b0;
        end
        if (emit_fire) begin
            if (r_hold_valid) begin
                out_load     = 1'b1;
                out_val.last = 1'b0;
            end
            n_hold       = emit_val;
            n_hold_valid = 1'b1;
        end
        n_out       = out_load ? out_val : r_out;
        n_out_valid = out_load ? 1'b1 : (r_out_valid && i_stall);

        if (i_cfg_we) begin
            n_div        = i_cfg_wdata;
            n_rem        = '0;
            n_bits       = '0;
            n_clr        = '0;
            n_head       = i_cfg_wdata;
            n_base       = i_cfg_wdata;
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_head       <= '0;
            r_base       <= '0;
            r_div        <= '0;
            r_rem        <= '0;
            r_bits       <= '0;
            r_clr        <= '0;
            r_count      <= '0;
            r_have       <= 1'b0;
            r_in_run     <= 1'b0;
            r_cut        <= 1'b0;
            r_words      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_base       <= n_base;
            r_div        <= n_div;
            r_rem        <= n_rem;
            r_bits       <= n_bits;
            r_clr        <= n_clr;
            r_count      <= n_count;
            r_have       <= n_have;
            r_in_run     <= n_in_run;
            r_cut        <= n_cut;
            r_words      <= n_words;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_slot <= n_head_slot;
        r_base_slot <= n_base_slot;
        r_ptr       <= n_ptr;
        r_off       <= n_off;
        r_wslot     <= n_wslot;
        r_prev      <= n_prev;
        r_hold      <= n_hold;
        r_out       <= n_out;
        r_quo       <= n_quo;
        r_part      <= n_part;
    end

    `RWRN_ASSERT_IMP(a_idle_hold_empty, r_state == ST_IDLE, !r_hold_valid, "hold busy in idle")
    `RWRN_ASSERT_IMP(a_slots_in_range, r_state != ST_INIT,
        ({1'b0, r_head_slot} < W_C) && ({1'b0, r_base_slot} < W_C), "slot out of range")
    `RWRN_ASSERT_NXT(a_arrival_two_cycles, r_state == ST_ARR,
        r_state == ST_IDLE || r_state == ST_INIT, "arrival overran")
    `RWRN_ASSERT(a_release_bound, r_count <= W_C, "release count past window")

endmodule

// ===== design/reorder_window_range_nak.sv =====
`timescale 1ns / 1ps
// Receive-side sequence tracker. An arrival (operation 0) reads its slot of
// the shared received/pending bitmap memory and then writes it unless it is
// already marked received; the memory has a single read and a single write
// port. A report (operation 1) releases received packets at the head one per
// cycle, then walks the pending map one slot per cycle unless the output
// side stalls. A two-word input queue takes words while a report runs. After
// reset and after every first_index write the block clears the bitmap memory
// and reduces first_index modulo WINDOW, while the input queue still takes up
// to two words.
module reorder_window_range_nak import rwrn_pkg::*; #(
    parameter int WINDOW           = 1024,
    parameter int MAX_REPORT_WORDS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_packet_index,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [IDX_W-1:0] o_range_index,
    output logic             o_run_start,
    output logic [CNT_W-1:0] o_released_count,
    output logic [IDX_W-1:0] o_next_expected,
    output logic             o_last
);

    t_cmd    cmd;
    logic    cmd_valid, cmd_take;
    t_result result;

    rwrn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_operation    (i_operation),
        .i_packet_index (i_packet_index),
        .o_stall        (o_stall),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_take     (cmd_take)
    );

    rwrn_engine #(
        .WINDOW           (WINDOW),
        .MAX_REPORT_WORDS (MAX_REPORT_WORDS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_result    (result),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

    assign o_kind           = result.kind;
    assign o_range_index    = result.range_index;
    assign o_run_start      = result.run_start;
    assign o_released_count = result.released_count;
    assign o_next_expected  = result.next_expected;
    assign o_last           = result.last;

endmodule
